@@ hw/rtl/itoa_pkg.sv @@
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, character codes and the power-of-ten table for the signed
// integer to decimal text converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  // Widths of the datapath.
  localparam int unsigned ValueW = 32;
  localparam int unsigned CharW  = 8;
  localparam int unsigned OperW  = 34;
  localparam int unsigned PosW   = 4;
  localparam int unsigned StepW  = 2;
  localparam int unsigned DigitW = 4;

  // Character codes.
  localparam logic [CharW-1:0] CharZero  = 8'd48;
  localparam logic [CharW-1:0] CharMinus = 8'd45;

  // Highest decimal position of a 32-bit magnitude.
  localparam logic [PosW-1:0] PosTop = 4'd9;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_SIGN  = 4'b0010,
    ST_SKIP  = 4'b0100,
    ST_DIGIT = 4'b1000
  } state_t;

  // Result of the shared compare-subtract unit.
  typedef struct packed {
    logic              ge;
    logic [ValueW-1:0] diff;
  } cmp_res_t;

  // Ten to the power of a decimal position.
  function automatic logic [OperW-1:0] pow10(input logic [PosW-1:0] pos);
    logic [OperW-1:0] p;
    unique case (pos)
      4'd0:    p = 34'd1;
      4'd1:    p = 34'd10;
      4'd2:    p = 34'd100;
      4'd3:    p = 34'd1000;
      4'd4:    p = 34'd10000;
      4'd5:    p = 34'd100000;
      4'd6:    p = 34'd1000000;
      4'd7:    p = 34'd10000000;
      4'd8:    p = 34'd100000000;
      4'd9:    p = 34'd1000000000;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

@@ hw/rtl/itoa_cmp_sub.sv @@
// ----------------------------------------------------------------------------
// itoa_cmp_sub
// Shared compare-subtract unit: tests magnitude against a scaled power of
// ten and gives the difference for the restoring step.
// ----------------------------------------------------------------------------
module itoa_cmp_sub (
  input  logic [itoa_pkg::ValueW-1:0] mag,
  input  logic [itoa_pkg::OperW-1:0]  oper,
  output itoa_pkg::cmp_res_t          res
);

  logic [itoa_pkg::OperW:0] wide_diff;

  // One wide subtract; the borrow out is the compare result.
  assign wide_diff = {1'b0, {(itoa_pkg::OperW - itoa_pkg::ValueW){1'b0}}, mag}
                   - {1'b0, oper};
  assign res.ge    = ~wide_diff[itoa_pkg::OperW];
  assign res.diff  = wide_diff[itoa_pkg::ValueW-1:0];

endmodule

@@ hw/rtl/signed_int_to_decimal_ascii_core.sv @@
// ----------------------------------------------------------------------------
// signed_int_to_decimal_ascii_core
// Converts a 32-bit two's complement integer to its decimal ASCII text,
// most significant character first, with a leading minus for negatives.
//
//   channel   signals                  handshake
//   input     value[31:0]              start, accepted when busy is low
//   result    char_code[7:0], last     strobe, one cycle, cannot stall
//
// An item keeps busy high through a sign step when negative, a skip
// step for each leading position plus one that enters the digit steps,
// and four compare-subtract steps per emitted digit (8, 4, 2 and 1 times
// the power of ten), all through the single compare-subtract unit. A
// digit leaves on the step that settles its low bit. Reset is synchronous
// and returns to idle with no strobe pending. The receiver cannot stall,
// so no result is ever held.
// ----------------------------------------------------------------------------
module signed_int_to_decimal_ascii_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  output logic                        busy,
  input  logic signed [itoa_pkg::ValueW-1:0] value,
  output logic [itoa_pkg::CharW-1:0]  char_code,
  output logic                        last,
  output logic                        strobe
);

  itoa_pkg::state_t state, state_next;

  logic [itoa_pkg::ValueW-1:0] mag, mag_next;
  logic [itoa_pkg::PosW-1:0]   pos, pos_next;
  logic [itoa_pkg::StepW-1:0]  step, step_next;
  logic [itoa_pkg::DigitW-1:0] digit, digit_next;
  logic [itoa_pkg::DigitW-1:0] digit_done;
  logic [itoa_pkg::OperW-1:0]  oper;
  logic [itoa_pkg::CharW-1:0]  char_code_next;
  logic                        last_next;
  logic                        strobe_next;
  itoa_pkg::cmp_res_t          cmp;

  assign busy = (state != itoa_pkg::ST_IDLE);

  // Operand: the power of ten at this position, scaled by the step weight.
  always_comb begin
    if (state == itoa_pkg::ST_DIGIT) begin
      oper = itoa_pkg::pow10(pos) << step;
    end else begin
      oper = itoa_pkg::pow10(pos);
    end
  end

  itoa_cmp_sub u_cmp_sub (
    .mag  (mag),
    .oper (oper),
    .res  (cmp)
  );

  // The digit with the current step's bit folded in.
  assign digit_done = digit | (cmp.ge ? (itoa_pkg::DigitW'(1) << step) : '0);

  // Sequencer.
  always_comb begin
    state_next     = state;
    mag_next       = mag;
    pos_next       = pos;
    step_next      = step;
    digit_next     = digit;
    char_code_next = char_code;
    last_next      = last;
    strobe_next    = 1'b0;
    unique case (state)
      itoa_pkg::ST_IDLE: begin
        if (start) begin
          mag_next   = value[itoa_pkg::ValueW-1] ? (itoa_pkg::ValueW'(0) - value) : value;
          pos_next   = itoa_pkg::PosTop;
          state_next = value[itoa_pkg::ValueW-1] ? itoa_pkg::ST_SIGN : itoa_pkg::ST_SKIP;
        end
      end
      itoa_pkg::ST_SIGN: begin
        char_code_next = itoa_pkg::CharMinus;
        last_next      = 1'b0;
        strobe_next    = 1'b1;
        state_next     = itoa_pkg::ST_SKIP;
      end
      itoa_pkg::ST_SKIP: begin
        // Drop leading positions; the units position is always emitted.
        if (!cmp.ge && (pos != '0)) begin
          pos_next = pos - 1'b1;
        end else begin
          step_next  = '1;
          digit_next = '0;
          state_next = itoa_pkg::ST_DIGIT;
        end
      end
      itoa_pkg::ST_DIGIT: begin
        if (cmp.ge) begin
          mag_next = cmp.diff;
        end
        digit_next = digit_done;
        if (step == '0) begin
          char_code_next = itoa_pkg::CharZero
                         + {{(itoa_pkg::CharW - itoa_pkg::DigitW){1'b0}}, digit_done};
          last_next      = (pos == '0);
          strobe_next    = 1'b1;
          step_next      = '1;
          digit_next     = '0;
          if (pos == '0) begin
            state_next = itoa_pkg::ST_IDLE;
          end else begin
            pos_next = pos - 1'b1;
          end
        end else begin
          step_next = step - 1'b1;
        end
      end
      default: begin
        state_next = itoa_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= itoa_pkg::ST_IDLE;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      strobe <= strobe_next;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    mag       <= mag_next;
    pos       <= pos_next;
    step      <= step_next;
    digit     <= digit_next;
    char_code <= char_code_next;
    last      <= last_next;
  end

  // A result only comes out of a conversion in progress.
  assert property (@(posedge clk) disable iff (rst) strobe |-> $past(busy))
    else $error("result strobe without a conversion in progress");

  // The final character of a run is never followed at once by another one.
  assert property (@(posedge clk) disable iff (rst) (strobe && last) |=> !strobe)
    else $error("result beat directly after the final character");

  // An accepted value always starts a conversion.
  assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("accepted value did not start a conversion");

  // A minus sign is never the final character.
  assert property (@(posedge clk) disable iff (rst)
    (strobe && (char_code == itoa_pkg::CharMinus)) |-> !last)
    else $error("minus sign flagged as final character");

endmodule
